// ===== design/ggap_pkg.sv =====
// ----------------------------------------------------------------------------
// ggap_pkg
// Shared constants, types and codes for the greedy goal-action planner.
// ----------------------------------------------------------------------------
package ggap_pkg;

    localparam int NUM_FACTS      = 32;
    localparam int NUM_ACTIONS    = 16;
    localparam int PLAN_DEPTH_MAX = 16;

    localparam int SLOT_W  = 4;
    localparam int COST_W  = 16;
    localparam int MASK_W  = 32;
    localparam int LIMIT_W = 8;
    localparam int ACT_W   = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int DEPTH_W = $clog2(PLAN_DEPTH_MAX + 1);
    localparam int BUF_W   = (PLAN_DEPTH_MAX > 1) ? $clog2(PLAN_DEPTH_MAX) : 1;
    localparam int SCAN_W  = $clog2(NUM_ACTIONS + 1);

    localparam logic [MASK_W-1:0] FACT_BITS = MASK_W'((65'd1 << NUM_FACTS) - 65'd1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PLAN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_EMIT
    } state_t;

    // One action entry as it travels along the cell chain.
    typedef struct packed {
        logic              written;
        logic [COST_W-1:0] cost;
        logic [MASK_W-1:0] need_mask;
        logic [MASK_W-1:0] need_value;
        logic [MASK_W-1:0] set_mask;
        logic [MASK_W-1:0] set_value;
    } entry_t;

    // Control from the sequencer to the chain.
    typedef struct packed {
        logic              load;
        logic [ACT_W-1:0]  slot;
        logic              rotate;
    } chain_ctrl_t;

endpackage

// ===== design/ggap_if.sv =====
// ----------------------------------------------------------------------------
// ggap_in_if / ggap_out_if
// Valid/ready channels carrying planner requests and results.
// ----------------------------------------------------------------------------
interface ggap_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [3:0]  action_slot;
    logic [15:0] action_cost;
    logic [31:0] precondition_mask;
    logic [31:0] precondition_value;
    logic [31:0] effect_mask;
    logic [31:0] effect_value;
    logic [31:0] goal_mask;
    logic [31:0] goal_value;
    logic [31:0] start_known;
    logic [31:0] start_value;
    logic [7:0]  depth_limit;
    modport source (output valid, operation, action_slot, action_cost, precondition_mask,
                    precondition_value, effect_mask, effect_value, goal_mask, goal_value,
                    start_known, start_value, depth_limit, input ready);
    modport sink (input valid, operation, action_slot, action_cost, precondition_mask,
                  precondition_value, effect_mask, effect_value, goal_mask, goal_value,
                  start_known, start_value, depth_limit, output ready);
endinterface

interface ggap_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] step_action;
    logic       step_valid;
    logic       plan_found;
    logic       last;
    modport source (output valid, step_action, step_valid, plan_found, last, input ready);
    modport sink (input valid, step_action, step_valid, plan_found, last, output ready);
endinterface

// ===== design/ggap_cell.sv =====
// ----------------------------------------------------------------------------
// ggap_cell
// One action entry of the rotating table; loads or passes to its neighbor.
// ----------------------------------------------------------------------------
module ggap_cell
    import ggap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  logic        load_sel,
    input  entry_t      load_entry,
    input  entry_t      prev_entry,
    output entry_t      entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && load_sel)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.rotate)
        begin
            entry_next = prev_entry;
        end
    end

    // Clear on reset so an unloaded cell reads as not written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== design/ggap_chain.sv =====
// ----------------------------------------------------------------------------
// ggap_chain
// Ring of action cells; the head cell is scanned once per rotation step.
// ----------------------------------------------------------------------------
module ggap_chain
    import ggap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chain_ctrl_t ctrl,
    input  entry_t      load_entry,
    output entry_t      head
);

    entry_t cells [NUM_ACTIONS];

    // Cell i holds action (i + offset) mod N; loads happen only at offset 0.
    for (genvar i = 0; i < NUM_ACTIONS; i++)
    begin : g_cell
        ggap_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_sel   (ctrl.slot == ACT_W'(i)),
            .load_entry (load_entry),
            .prev_entry (cells[(i + 1) % NUM_ACTIONS]),
            .entry      (cells[i])
        );
    end

    assign head = cells[0];

endmodule

// ===== design/greedy_goal_action_planner_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_goal_action_planner_unit
// Greedy forward planner over boolean facts with a rotating action table.
// ----------------------------------------------------------------------------
// A load request writes one action entry and gives no result.
// A plan request runs up to min(depth_limit, PLAN_DEPTH_MAX) depths; each
// depth rotates the ring of NUM_ACTIONS cells once past a single compare unit,
// then closes the scan and applies the winner; a zero depth limit skips the
// scan and only checks the goal on the start facts. The results then stream
// out, each held while the receiver is not ready. Requests are accepted only
// while the planner is idle; the ring always returns to its home rotation.
module greedy_goal_action_planner_unit
    import ggap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ggap_in_if.sink  in_req,
    ggap_out_if.source out_res
);

    state_t state_reg, state_next;

    logic [MASK_W-1:0]  known_reg, known_next;
    logic [MASK_W-1:0]  value_reg, value_next;
    logic [MASK_W-1:0]  goal_m_reg, goal_v_reg;
    logic [DEPTH_W-1:0] limit_reg;
    logic [DEPTH_W-1:0] steps_reg, steps_next;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic               best_ok_reg, best_ok_next;
    logic [ACT_W-1:0]   best_idx_reg, best_idx_next;
    logic [COST_W-1:0]  best_cost_reg, best_cost_next;
    logic [MASK_W-1:0]  best_sm_reg, best_sm_next;
    logic [MASK_W-1:0]  best_sv_reg, best_sv_next;
    logic [DEPTH_W-1:0] emit_reg, emit_next;
    logic               found_reg, found_next;
    logic [ACT_W-1:0]   step_buf [PLAN_DEPTH_MAX];

    chain_ctrl_t ctrl;
    entry_t      load_entry, head;

    logic accept, is_plan;
    assign accept  = in_req.valid && in_req.ready;
    assign is_plan = (in_req.operation == OP_PLAN);

    assign load_entry.written    = 1'b1;
    assign load_entry.cost       = in_req.action_cost;
    assign load_entry.need_mask  = in_req.precondition_mask;
    assign load_entry.need_value = in_req.precondition_value;
    assign load_entry.set_mask   = in_req.effect_mask;
    assign load_entry.set_value  = in_req.effect_value;

    ggap_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .load_entry (load_entry),
        .head       (head)
    );

    // Qualify the head cell against the current facts.
    logic [MASK_W-1:0] nm, sm, gm;
    logic head_ok, goal_now;
    logic [MASK_W-1:0] app_known, app_value;
    assign nm = head.need_mask & FACT_BITS;
    assign sm = head.set_mask & FACT_BITS;
    assign head_ok = head.written
        && ((nm & ~known_reg) == '0) && (((value_reg ^ head.need_value) & nm) == '0)
        && (((sm & ~known_reg) != '0) || (((value_reg ^ head.set_value) & sm) != '0));

    assign app_known = known_reg | (best_sm_reg & FACT_BITS);
    assign app_value = (value_reg & ~(best_sm_reg & FACT_BITS))
                     | (best_sv_reg & best_sm_reg & FACT_BITS);

    assign gm = goal_m_reg & FACT_BITS;
    function automatic logic goal_holds(input logic [MASK_W-1:0] k,
                                        input logic [MASK_W-1:0] v);
        goal_holds = ((gm & ~k) == '0) && (((v ^ goal_v_reg) & gm) == '0);
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_plan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == SCAN_W'(NUM_ACTIONS))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_EMIT;
                if (best_ok_reg && !goal_holds(app_known, app_value)
                    && (steps_reg + 1'b1) < limit_reg)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (out_res.ready && (!found_reg || steps_reg == '0
                    || emit_reg + 1'b1 == steps_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        known_next     = known_reg;
        value_next     = value_reg;
        steps_next     = steps_reg;
        scan_next      = scan_reg;
        best_ok_next   = best_ok_reg;
        best_idx_next  = best_idx_reg;
        best_cost_next = best_cost_reg;
        best_sm_next   = best_sm_reg;
        best_sv_next   = best_sv_reg;
        emit_next      = emit_reg;
        found_next     = found_reg;
        ctrl.load      = 1'b0;
        ctrl.slot      = in_req.action_slot[ACT_W-1:0];
        ctrl.rotate    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Drop loads aimed past the end of the table.
                if (accept && !is_plan
                    && (SLOT_W+1)'(in_req.action_slot) < (SLOT_W+1)'(NUM_ACTIONS))
                begin
                    ctrl.load = 1'b1;
                end
                if (accept && is_plan)
                begin
                    known_next  = in_req.start_known & FACT_BITS;
                    value_next  = in_req.start_value & in_req.start_known & FACT_BITS;
                    steps_next  = '0;
                    scan_next   = '0;
                    best_ok_next = 1'b0;
                    emit_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg != SCAN_W'(NUM_ACTIONS))
                begin
                    ctrl.rotate = 1'b1;
                    scan_next   = scan_reg + 1'b1;
                    // Strict compare keeps the lower index on a cost tie.
                    if (head_ok && (!best_ok_reg || head.cost < best_cost_reg))
                    begin
                        best_ok_next   = 1'b1;
                        best_idx_next  = scan_reg[ACT_W-1:0];
                        best_cost_next = head.cost;
                        best_sm_next   = head.set_mask;
                        best_sv_next   = head.set_value;
                    end
                end
            end
            ST_APPLY:
            begin
                scan_next    = '0;
                best_ok_next = 1'b0;
                if (best_ok_reg)
                begin
                    known_next = app_known;
                    value_next = app_value;
                    steps_next = steps_reg + 1'b1;
                    found_next = goal_holds(app_known, app_value);
                end
                else
                begin
                    found_next = goal_holds(known_reg, value_reg);
                end
            end
            ST_EMIT:
            begin
                if (out_res.ready)
                begin
                    emit_next = emit_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Zero limit skips the scan: check goal on the start facts.
    logic zero_lim;
    assign zero_lim = (in_req.depth_limit == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            known_reg <= '0;
            value_reg <= '0;
        end
        else
        begin
            state_reg <= (state_reg == ST_IDLE && accept && is_plan && zero_lim)
                         ? ST_APPLY : state_next;
            known_reg <= known_next;
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg     <= steps_next;
        scan_reg      <= scan_next;
        best_ok_reg   <= best_ok_next;
        best_idx_reg  <= best_idx_next;
        best_cost_reg <= best_cost_next;
        best_sm_reg   <= best_sm_next;
        best_sv_reg   <= best_sv_next;
        emit_reg      <= emit_next;
        found_reg     <= found_next;
        if (state_reg == ST_IDLE && accept && is_plan)
        begin
            goal_m_reg <= in_req.goal_mask;
            goal_v_reg <= in_req.goal_value;
            limit_reg  <= (in_req.depth_limit > LIMIT_W'(PLAN_DEPTH_MAX))
                          ? DEPTH_W'(PLAN_DEPTH_MAX) : in_req.depth_limit[DEPTH_W-1:0];
        end
        if (state_reg == ST_APPLY && best_ok_reg)
        begin
            step_buf[steps_reg[BUF_W-1:0]] <= best_idx_reg;
        end
    end

    // Outputs
    logic multi;
    assign multi = found_reg && (steps_reg != '0);
    assign in_req.ready        = (state_reg == ST_IDLE);
    assign out_res.valid       = (state_reg == ST_EMIT);
    assign out_res.step_action = multi ? 4'(step_buf[emit_reg[BUF_W-1:0]]) : 4'd0;
    assign out_res.step_valid  = multi;
    assign out_res.plan_found  = found_reg;
    assign out_res.last        = !multi || (emit_reg + 1'b1 == steps_reg);

endmodule

// ===== design/ggap_checker.sv =====
// ----------------------------------------------------------------------------
// ggap_checker
// Port-level checks on the planner's result stream.
// ----------------------------------------------------------------------------
module ggap_checker
    import ggap_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic step_valid,
    input logic plan_found,
    input logic last,
    input logic [3:0] step_action
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_action) && $stable(last))
        else $error("result changed while stalled");

    // An empty result is always the final one.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !step_valid |-> last && step_action == 4'd0)
        else $error("empty result not last");

    // A step only comes from a found plan.
    a_step_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_valid |-> plan_found)
        else $error("step without plan");

    // No new request is taken while results are pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid)
        else $error("request accepted during result stream");

endmodule

bind greedy_goal_action_planner_unit ggap_checker u_ggap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .step_valid  (out_res.step_valid),
    .plan_found  (out_res.plan_found),
    .last        (out_res.last),
    .step_action (out_res.step_action)
);

// ===== bench/ggap_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ggap_tb_if
// Bench-side helper types for the planner regression.
// ----------------------------------------------------------------------------
package ggap_tb_pkg;

    import ggap_pkg::*;

    // One plan result as seen on the output channel.
    typedef struct packed {
        logic [3:0] step_action;
        logic       step_valid;
        logic       plan_found;
        logic       last;
    } plan_result_t;

    // One request as driven on the input channel.
    typedef struct packed {
        logic        operation;
        logic [3:0]  action_slot;
        logic [15:0] action_cost;
        logic [31:0] precondition_mask;
        logic [31:0] precondition_value;
        logic [31:0] effect_mask;
        logic [31:0] effect_value;
        logic [31:0] goal_mask;
        logic [31:0] goal_value;
        logic [31:0] start_known;
        logic [31:0] start_value;
        logic [7:0]  depth_limit;
    } plan_request_t;

endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the greedy goal-action planner: a directed table of load
// and plan requests, then random action tables and plans, all checked
// against a bench-side planner model under several flow-control phases.
// ----------------------------------------------------------------------------
module tb;

    import ggap_pkg::*;
    import ggap_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic clk;
    logic rst_n;

    ggap_in_if  req_ch ();
    ggap_out_if res_ch ();

    greedy_goal_action_planner_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (req_ch.sink),
        .out_res (res_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Planner model: its own copy of the action table and fact store.
    // ------------------------------------------------------------------
    logic [15:0] mdl_cost     [NUM_ACTIONS];
    logic [31:0] mdl_need_m   [NUM_ACTIONS];
    logic [31:0] mdl_need_v   [NUM_ACTIONS];
    logic [31:0] mdl_set_m    [NUM_ACTIONS];
    logic [31:0] mdl_set_v    [NUM_ACTIONS];
    logic        mdl_written  [NUM_ACTIONS];

    plan_result_t expected_results [$];

    int error_count;
    int plans_sent;
    int loads_sent;
    int results_seen;
    int found_plans;

    // Facts satisfy a predicate when all masked facts are known and match.
    function automatic logic facts_hold(logic [31:0] known, logic [31:0] value,
                                        logic [31:0] mask, logic [31:0] want);
        logic [31:0] m;
        m = mask & FACT_BITS;
        if ((m & ~known) != 32'd0)
            return 1'b0;
        return ((value ^ want) & m) == 32'd0;
    endfunction

    // Apply one request to the model and queue what it should produce.
    task automatic predict_plan(input plan_request_t r);
        logic [31:0] known;
        logic [31:0] value;
        logic [31:0] m;
        logic [3:0]  steps [$];
        int          depth_cap;
        int          best;
        logic [15:0] best_cost;
        logic        found;
        plan_result_t res;
        if (r.operation == OP_LOAD)
        begin
            mdl_cost[r.action_slot]    = r.action_cost;
            mdl_need_m[r.action_slot]  = r.precondition_mask;
            mdl_need_v[r.action_slot]  = r.precondition_value;
            mdl_set_m[r.action_slot]   = r.effect_mask;
            mdl_set_v[r.action_slot]   = r.effect_value;
            mdl_written[r.action_slot] = 1'b1;
            return;
        end
        known = r.start_known & FACT_BITS;
        value = r.start_value & known;
        depth_cap = (r.depth_limit > PLAN_DEPTH_MAX) ? PLAN_DEPTH_MAX : r.depth_limit;
        for (int d = 0; d < depth_cap; d++)
        begin
            best = -1;
            best_cost = '0;
            for (int a = 0; a < NUM_ACTIONS; a++)
            begin
                if (!mdl_written[a])
                    continue;
                if (!facts_hold(known, value, mdl_need_m[a], mdl_need_v[a]))
                    continue;
                // an action that changes nothing is skipped
                if (facts_hold(known, value, mdl_set_m[a], mdl_set_v[a]))
                    continue;
                if (best < 0 || mdl_cost[a] < best_cost)
                begin
                    best = a;
                    best_cost = mdl_cost[a];
                end
            end
            if (best < 0)
                break;
            m = mdl_set_m[best] & FACT_BITS;
            known = known | m;
            value = (value & ~m) | (mdl_set_v[best] & m);
            steps.insert(steps.size(), 4'(best));
            if (facts_hold(known, value, r.goal_mask, r.goal_value))
                break;
        end
        found = facts_hold(known, value, r.goal_mask, r.goal_value);
        if (!found || steps.size() == 0)
        begin
            res = '{step_action: 4'd0, step_valid: 1'b0, plan_found: found, last: 1'b1};
            expected_results.insert(expected_results.size(), res);
        end
        else
        begin
            foreach (steps[i])
            begin
                res = '{step_action: steps[i], step_valid: 1'b1, plan_found: 1'b1,
                        last: (i == steps.size() - 1)};
                expected_results.insert(expected_results.size(), res);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Flow control knobs, set per phase by the stimulus process.
    // ------------------------------------------------------------------
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off_recv;
    int  hold_off_cycles;

    // Receiver: stall at random, or hold off for a long counted stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready    <= 1'b0;
            hold_off_cycles <= 0;
        end
        else if (hold_off_recv && hold_off_cycles < 300)
        begin
            res_ch.ready    <= 1'b0;
            hold_off_cycles <= hold_off_cycles + 1;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        plan_result_t exp_res;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: action %0d", res_ch.step_action);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (res_ch.step_action !== exp_res.step_action)
                begin
                    $error("step_action expected %0d actual %0d",
                           exp_res.step_action, res_ch.step_action);
                    error_count++;
                end
                if (res_ch.step_valid !== exp_res.step_valid)
                begin
                    $error("step_valid expected %0d actual %0d",
                           exp_res.step_valid, res_ch.step_valid);
                    error_count++;
                end
                if (res_ch.plan_found !== exp_res.plan_found)
                begin
                    $error("plan_found expected %0d actual %0d",
                           exp_res.plan_found, res_ch.plan_found);
                    error_count++;
                end
                if (res_ch.last !== exp_res.last)
                begin
                    $error("last expected %0d actual %0d", exp_res.last, res_ch.last);
                    error_count++;
                end
                if (exp_res.last && exp_res.plan_found)
                    found_plans++;
            end
        end
    end

    // Watchdog: count cycles in which neither channel completes a transfer.
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("greedy_goal_action_planner_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic drive_idle();
        req_ch.valid              <= 1'b0;
        req_ch.operation          <= OP_LOAD;
        req_ch.action_slot        <= '0;
        req_ch.action_cost        <= '0;
        req_ch.precondition_mask  <= '0;
        req_ch.precondition_value <= '0;
        req_ch.effect_mask        <= '0;
        req_ch.effect_value       <= '0;
        req_ch.goal_mask          <= '0;
        req_ch.goal_value         <= '0;
        req_ch.start_known        <= '0;
        req_ch.start_value        <= '0;
        req_ch.depth_limit        <= '0;
    endtask

    // Offer one request, idling first at random, and hold until accepted.
    // Valid stays up after the accept; the next offer or a wait drops it.
    task automatic send_request(input plan_request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid              <= 1'b1;
        req_ch.operation          <= r.operation;
        req_ch.action_slot        <= r.action_slot;
        req_ch.action_cost        <= r.action_cost;
        req_ch.precondition_mask  <= r.precondition_mask;
        req_ch.precondition_value <= r.precondition_value;
        req_ch.effect_mask        <= r.effect_mask;
        req_ch.effect_value       <= r.effect_value;
        req_ch.goal_mask          <= r.goal_mask;
        req_ch.goal_value         <= r.goal_value;
        req_ch.start_known        <= r.start_known;
        req_ch.start_value        <= r.start_value;
        req_ch.depth_limit        <= r.depth_limit;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_plan(r);
        if (r.operation == OP_LOAD)
            loads_sent++;
        else
            plans_sent++;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic plan_request_t make_load(int slot, int cost,
                                                logic [31:0] nm, logic [31:0] nv,
                                                logic [31:0] sm, logic [31:0] sv);
        plan_request_t r;
        r = '0;
        r.operation          = OP_LOAD;
        r.action_slot        = 4'(slot);
        r.action_cost        = 16'(cost);
        r.precondition_mask  = nm;
        r.precondition_value = nv;
        r.effect_mask        = sm;
        r.effect_value       = sv;
        return r;
    endfunction

    function automatic plan_request_t make_plan(logic [31:0] gm, logic [31:0] gv,
                                                logic [31:0] sk, logic [31:0] sv,
                                                int depth);
        plan_request_t r;
        r = '0;
        r.operation   = OP_PLAN;
        r.goal_mask   = gm;
        r.goal_value  = gv;
        r.start_known = sk;
        r.start_value = sv;
        r.depth_limit = 8'(depth);
        return r;
    endfunction

    // Random words biased toward few set bits so chains of actions connect.
    function automatic logic [31:0] sparse_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'd1 << $urandom_range(31);
            default: return $urandom() & $urandom() & $urandom() & 32'h0000_00ff;
        endcase
    endfunction

    // A random chain: slot k needs fact k-1 set and sets fact k.
    task automatic load_chain(input int n);
        logic [31:0] noise;
        for (int k = 0; k < n; k++)
        begin
            noise = (k == 0) ? 32'd0 : (32'd1 << (k - 1));
            send_request(make_load(k, $urandom_range(65535), noise, noise,
                                   32'd1 << k, 32'd1 << k));
        end
    endtask

    // Table row: the request and, where obvious, its single result.
    typedef struct {
        plan_request_t req;
        bit            has_fixed;
        plan_result_t  fixed;
    } directed_row_t;

    directed_row_t directed [$];

    task automatic build_directed();
        directed_row_t row;
        plan_result_t none_found;
        plan_result_t empty_found;
        none_found  = '{step_action: 4'd0, step_valid: 1'b0, plan_found: 1'b0, last: 1'b1};
        empty_found = '{step_action: 4'd0, step_valid: 1'b0, plan_found: 1'b1, last: 1'b1};
        // empty table: goal unmet gives no plan, empty goal gives an empty plan
        row = '{make_plan(32'h1, 32'h1, 32'h0, 32'h0, 16), 1, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 255), 1, empty_found};
        directed.insert(directed.size(), row);
        // extreme field values on loads
        row = '{make_load(15, 65535, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff, 32'hffff_ffff), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_load(0, 0, 32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_load(1, 5, 32'h1, 32'h1, 32'h0000_0002, 32'h0000_0002), 0, none_found};
        directed.insert(directed.size(), row);
        // equal cost to slot 1: the lower index must win the tie
        row = '{make_load(2, 5, 32'h1, 32'h1, 32'h0000_0002, 32'h0000_0002), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_load(3, 9, 32'h2, 32'h2, 32'h8000_0000, 32'h0), 0, none_found};
        directed.insert(directed.size(), row);
        // zero depth limit, goal checked on start facts only
        row = '{make_plan(32'h1, 32'h1, 32'h0, 32'h0, 0), 1, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'h1, 32'h1, 32'h1, 32'h1, 0), 1, empty_found};
        directed.insert(directed.size(), row);
        // goal true at start: search still runs
        row = '{make_plan(32'h0, 32'h0, 32'h0, 32'h0, 3), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'h2, 32'h2, 32'h0, 32'h0, 16), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'h8000_0000, 32'h0, 32'h0, 32'h0, 255), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 16), 0,
                none_found};
        directed.insert(directed.size(), row);
        // start value outside the known mask is dropped
        row = '{make_plan(32'h4, 32'h4, 32'h0, 32'hffff_ffff, 1), 0, none_found};
        directed.insert(directed.size(), row);
        row = '{make_plan(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0, 2), 0, none_found};
        directed.insert(directed.size(), row);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        plan_request_t r;
        int            phase;
        logic [351:0]  raw_bits;
        error_count   = 0;
        plans_sent    = 0;
        loads_sent    = 0;
        results_seen  = 0;
        found_plans   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_recv  = 1'b0;
        for (int a = 0; a < NUM_ACTIONS; a++)
            mdl_written[a] = 1'b0;
        rst_n = 1'b0;
        drive_idle();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (directed[i])
        begin
            if (directed[i].has_fixed)
                wait_drained();
            send_request(directed[i].req);
            if (directed[i].has_fixed && expected_results.size() == 1
                && expected_results[0] != directed[i].fixed)
            begin
                $error("directed row %0d: model disagrees with table", i);
                error_count++;
            end
        end
        wait_drained();

        // Random part: four flow-control phases; a new chain is loaded every 20 rounds.
        for (int n = 0; n < 100; n++)
        begin
            phase = n / 25;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (n == 60)
            begin
                // long receiver hold-off while plans keep arriving
                hold_off_recv = 1'b1;
                for (int k = 0; k < 4; k++)
                    send_request(make_plan(32'h3, 32'h3, 32'h0, 32'h0, 16));
                hold_off_recv = 1'b0;
            end
            if (n % 20 == 0)
            begin
                // sender pauses until everything has come back
                wait_drained();
                load_chain($urandom_range(16, 1));
            end
            case ($urandom_range(9))
                0, 1:
                begin
                    r = make_load($urandom_range(15), $urandom_range(65535),
                                  sparse_word(), sparse_word(), sparse_word(), sparse_word());
                    if ($urandom_range(3) == 0)
                        r.action_cost = 16'($urandom_range(3));
                end
                2:
                begin
                    raw_bits = {$urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom()};
                    r = raw_bits[$bits(plan_request_t)-1:0];
                end
                default:
                begin
                    r = make_plan(sparse_word(), sparse_word(), sparse_word(), sparse_word(),
                                  ($urandom_range(7) == 0) ? $urandom_range(255)
                                                          : $urandom_range(16));
                    if ($urandom_range(1))
                    begin
                        // goal inside what a chain can reach
                        r.goal_mask   = 32'd1 << $urandom_range(15);
                        r.goal_value  = r.goal_mask;
                        r.start_known = 32'h0;
                    end
                end
            endcase
            send_request(r);
        end

        wait_drained();
        req_ch.valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d plans, %0d results, %0d plans found",
                 loads_sent, plans_sent, results_seen, found_plans);
        if (error_count == 0 && expected_results.size() == 0)
            $display("greedy_goal_action_planner_unit regression: pass");
        else
            $display("greedy_goal_action_planner_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ggap_pkg.sv
design/ggap_if.sv
design/ggap_cell.sv
design/ggap_chain.sv
design/greedy_goal_action_planner_unit.sv
design/ggap_checker.sv
bench/ggap_tb_if.sv
bench/tb.sv
